>>> hw/rtl/sus_pkg.sv
// Shared widths, codes and cell control type for the sorted unique id set.
package sus_pkg;

  localparam int ID_W         = 31;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_W      = 6;
  localparam int CAPACITY_DEF = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Per-cell commands issued by the sequencer.
  typedef struct packed {
    logic cmp_en;
    logic load_key;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sus_cell.sv
// One storage cell of the id chain: holds an id, compares it and shifts.
module sus_cell
  import sus_pkg::*;
(
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [ID_W-1:0] key,
  input  logic [ID_W-1:0] left_id,
  input  logic [ID_W-1:0] right_id,
  output logic [ID_W-1:0] id,
  output logic            lt,
  output logic            eq
);

  logic [ID_W-1:0] id_r;
  logic            lt_r;
  logic            eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      id_r <= key;
    end else if (ctrl.take_left) begin
      id_r <= left_id;
    end else if (ctrl.take_right) begin
      id_r <= right_id;
    end
    if (ctrl.cmp_en) begin
      lt_r <= (id_r < key);
      eq_r <= (id_r == key);
    end
  end

  assign id = id_r;
  assign lt = lt_r;
  assign eq = eq_r;

endmodule

>>> hw/rtl/sorted_unique_id_set.sv
// Sorted unique id set: a chain of compare-and-shift cells with a small sequencer.
// Each item is accepted, compared in all cells, then shifted; the shift step registers
// its result in the output register, and no new item is accepted until that is done.
// A result waiting in the output register stalls only the shift step.
// Reset (synchronous, rst_n low) empties the set and clears the output valid;
// the cell contents are not cleared, entries past the count are never used.
module sorted_unique_id_set
  import sus_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [ID_W-1:0]     in_student_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [ENTRY_W-1:0]  out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 act_r;
  logic [ID_W-1:0]      key_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r, status_nxt;
  logic [ENTRY_W-1:0]   out_entry_count_r;

  logic [ID_W-1:0]      id_w [CAPACITY];
  logic [CAPACITY-1:0]  lt_w, eq_w, valid_w, g_w, g_prev_w, first_ge_w;
  cell_ctrl_t           ctrl_w [CAPACITY];

  logic present, full, can_out, apply_go, do_ins, do_rem, in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign can_out  = !out_valid_r || !out_stall;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_w[i] = (CNT_W'(i) < count_r);
    end
  end

  // Occupied cells holding an id below the key form a prefix; the first cell
  // past that prefix is where the key belongs.
  assign g_w        = valid_w & lt_w;
  assign g_prev_w   = {g_w[CAPACITY-2:0], 1'b1};
  assign first_ge_w = ~g_w & g_prev_w;
  assign present    = |(valid_w & eq_w);
  assign full       = (count_r == CNT_W'(CAPACITY));

  assign apply_go = (state_r == S_APPLY) && can_out;
  assign do_ins   = apply_go && (act_r == ACT_INSERT) && !full && !present;
  assign do_rem   = apply_go && (act_r == ACT_REMOVE) && present;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl_w[i].cmp_en     = (state_r == S_CMP);
      ctrl_w[i].load_key   = do_ins && first_ge_w[i];
      ctrl_w[i].take_left  = do_ins && !g_w[i] && !first_ge_w[i];
      ctrl_w[i].take_right = do_rem && !g_w[i];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sus_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl_w[i]),
      .key      (key_r),
      .left_id  ((i == 0) ? key_r : id_w[(i == 0) ? 0 : i - 1]),
      .right_id (id_w[(i == CAPACITY - 1) ? i : i + 1]),
      .id       (id_w[i]),
      .lt       (lt_w[i]),
      .eq       (eq_w[i])
    );
  end

  always_comb begin
    if (act_r == ACT_INSERT) begin
      status_nxt = full ? ST_FULL : (present ? ST_PRESENT : ST_OK);
    end else begin
      status_nxt = present ? ST_OK : ST_ABSENT;
    end
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: if (can_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      key_r <= in_student_id;
    end
    if (apply_go) begin
      out_status_r      <= status_nxt;
      out_entry_count_r <= ENTRY_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go && status_nxt == ST_FULL |=> count_r == CNT_W'(CAPACITY))
    else $error("full status with free room");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_APPLY |=> $stable(count_r))
    else $error("entry count changed outside the shift step");

  a_single_edit: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins && do_rem))
    else $error("insert and remove in the same cycle");

endmodule
